@@ hw/rtl/gitm_pkg.sv @@
// Shared constants and types for the greedy IoU track matcher.
`default_nettype none
package gitm_pkg;
	localparam int MaxTracks = 64;
	localparam int CoordBits = 12;
	localparam int IdBits = $clog2(MaxTracks);
	localparam int CntBits = $clog2(MaxTracks + 1);
	localparam int CtrBits = CoordBits + 1;
	localparam int BoxBits = 4 * CoordBits;
	localparam int CenBits = 2 * CtrBits;
	localparam int AreaBits = 2 * CoordBits;
	localparam int ThrBits = 9;
	localparam logic [ThrBits-1:0] ThrReset = 9'd128;

	localparam logic CMD_DET = 1'b0;
	localparam logic CMD_EOF = 1'b1;
	localparam logic KIND_DET = 1'b0;
	localparam logic KIND_LIST = 1'b1;

	typedef struct packed {
		logic [CoordBits-1:0] x;
		logic [CoordBits-1:0] y;
		logic [CoordBits-1:0] w;
		logic [CoordBits-1:0] h;
	} box_t;

	typedef struct packed {
		logic [CtrBits-1:0] cx;
		logic [CtrBits-1:0] cy;
	} ctr_t;

	typedef struct packed {
		logic cmd;
		box_t box;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [IdBits-1:0] id;
		logic is_new;
		logic dropped;
		box_t box;
		ctr_t ctr;
		logic last;
	} res_t;
endpackage
`default_nettype wire

@@ hw/rtl/gitm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module gitm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/gitm_front.sv @@
// Front end: accepts commands and queues them for the matcher.
`default_nettype none
module gitm_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           busy_in,
	input  wire gitm_pkg::item_t item_in,
	input  wire logic           pop,
	output logic                q_valid,
	output gitm_pkg::item_t     q_item,
	output logic                full
);
	// two-entry queue
	gitm_pkg::item_t ent_q [2];
	logic [1:0] cnt_q;
	logic push;
	assign push = start && !busy_in;
	assign full = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = ent_q[0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
	always_ff @(posedge clk) begin
		// a beat lands at the head when the queue is or becomes empty
		if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) ent_q[0] <= item_in;
		else if (pop) ent_q[0] <= ent_q[1];
		if (push && cnt_q == 2'd1 && !pop) ent_q[1] <= item_in;
	end
endmodule
`default_nettype wire

@@ hw/rtl/gitm_back.sv @@
// Back end: scans committed tracks, updates the table and lists tracks.
`default_nettype none
module gitm_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  wire gitm_pkg::item_t              q_item,
	input  wire logic [gitm_pkg::ThrBits-1:0] thr,
	output logic                              pop,
	output logic                              idle,
	output logic                              res_valid,
	output gitm_pkg::res_t                    res
);
	typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_PROD, S_THR, S_TEST, S_LRD,
		S_LOUT} state_t;
	state_t state_q;
	gitm_pkg::box_t det_q;
	gitm_pkg::ctr_t dctr_q;
	logic [gitm_pkg::IdBits-1:0] idx_q;
	logic [gitm_pkg::CntBits-1:0] tcnt_q, ccnt_q;
	logic [gitm_pkg::AreaBits-1:0] inter_q, areaa_q, areab_q;
	logic [gitm_pkg::CoordBits-1:0] iw_q, ih_q;
	logic [gitm_pkg::AreaBits+1:0] uni_q;
	logic [gitm_pkg::AreaBits+8:0] lhs_q;
	logic [gitm_pkg::AreaBits+10:0] rhs_q;
	logic uzero_q;

	logic bwe, cwe;
	logic [gitm_pkg::IdBits-1:0] waddr, raddr;
	gitm_pkg::box_t bwdata, brd;
	gitm_pkg::ctr_t cwdata, crd;

	gitm_ram #(.Width(gitm_pkg::BoxBits), .Depth(gitm_pkg::MaxTracks)) u_box (
		.clk(clk), .we(bwe), .waddr(waddr), .wdata(bwdata), .raddr(raddr), .rdata(brd));
	gitm_ram #(.Width(gitm_pkg::CenBits), .Depth(gitm_pkg::MaxTracks)) u_ctr (
		.clk(clk), .we(cwe), .waddr(waddr), .wdata(cwdata), .raddr(raddr), .rdata(crd));

	assign raddr = idx_q;
	assign idle = (state_q == S_IDLE);

	// overlap of detection and stored box
	logic [gitm_pkg::CoordBits:0] ax2, bx2, ay2, by2, x1, y1, x2, y2;
	always_comb begin
		ax2 = {1'b0, det_q.x} + {1'b0, det_q.w};
		bx2 = {1'b0, brd.x} + {1'b0, brd.w};
		ay2 = {1'b0, det_q.y} + {1'b0, det_q.h};
		by2 = {1'b0, brd.y} + {1'b0, brd.h};
		x1 = (det_q.x > brd.x) ? {1'b0, det_q.x} : {1'b0, brd.x};
		y1 = (det_q.y > brd.y) ? {1'b0, det_q.y} : {1'b0, brd.y};
		x2 = (ax2 < bx2) ? ax2 : bx2;
		y2 = (ay2 < by2) ? ay2 : by2;
	end
	logic [gitm_pkg::CoordBits:0] dxw, dyh;
	assign dxw = x2 - x1;
	assign dyh = y2 - y1;
	logic [gitm_pkg::AreaBits-1:0] iprod;
	assign iprod = iw_q * ih_q;

	logic scan_more;
	assign scan_more = ({1'b0, idx_q} + 1'b1) < ccnt_q;
	logic is_match;
	assign is_match = !uzero_q && (lhs_q > rhs_q);
	logic table_full;
	assign table_full = (tcnt_q == gitm_pkg::CntBits'(gitm_pkg::MaxTracks));

	always_comb begin
		bwe = 1'b0;
		cwe = 1'b0;
		waddr = idx_q;
		bwdata = det_q;
		cwdata = dctr_q;
		if (state_q == S_TEST && is_match) cwe = 1'b1;
		if ((state_q == S_TEST && !is_match && !scan_more) ||
		    (state_q == S_RD && ccnt_q == '0)) begin
			if (!table_full) begin
				bwe = 1'b1;
				cwe = 1'b1;
				waddr = tcnt_q[gitm_pkg::IdBits-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			tcnt_q <= '0;
			ccnt_q <= '0;
			pop <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			pop <= 1'b0;
			res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (q_valid && !pop) begin
						pop <= 1'b1;
						if (q_item.cmd == gitm_pkg::CMD_EOF) begin
							ccnt_q <= tcnt_q;
							if (tcnt_q != '0) state_q <= S_LRD;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (ccnt_q == '0) begin
						res_valid <= 1'b1;
						if (!table_full) tcnt_q <= tcnt_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: state_q <= S_PROD;
				S_PROD: state_q <= S_THR;
				S_THR: state_q <= S_TEST;
				S_TEST: begin
					if (is_match) begin
						res_valid <= 1'b1;
						state_q <= S_IDLE;
					end else if (scan_more) begin
						// next track needs its own RAM read in S_RD
						idx_q <= idx_q + 1'b1;
						state_q <= S_RD;
					end else begin
						res_valid <= 1'b1;
						if (!table_full) tcnt_q <= tcnt_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LRD: state_q <= S_LOUT;
				S_LOUT: begin
					res_valid <= 1'b1;
					if (({1'b0, idx_q} + 1'b1) == tcnt_q) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_LRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			det_q <= q_item.box;
			dctr_q.cx <= {1'b0, q_item.box.x} + {2'b0, q_item.box.w[gitm_pkg::CoordBits-1:1]};
			dctr_q.cy <= {1'b0, q_item.box.y} + {2'b0, q_item.box.h[gitm_pkg::CoordBits-1:1]};
		end
		if (state_q == S_CMP) begin
			iw_q <= (x2 > x1) ? dxw[gitm_pkg::CoordBits-1:0] : '0;
			ih_q <= (y2 > y1) ? dyh[gitm_pkg::CoordBits-1:0] : '0;
			areaa_q <= det_q.w * det_q.h;
			areab_q <= brd.w * brd.h;
		end
		if (state_q == S_PROD) begin
			inter_q <= iprod;
			uni_q <= {2'b0, areaa_q} + {2'b0, areab_q} - {2'b0, iprod};
		end
		// compare needs inter and union registered: lhs and rhs load in THR, the state after PROD
		lhs_q <= {1'b0, inter_q, 8'd0};
		rhs_q <= thr * uni_q;
		uzero_q <= (uni_q == '0);
		if (state_q == S_RD || state_q == S_TEST || state_q == S_LOUT) begin
			res.kind <= gitm_pkg::KIND_DET;
			res.last <= 1'b1;
			res.is_new <= 1'b0;
			res.dropped <= 1'b0;
			res.id <= idx_q;
			res.box <= brd;
			res.ctr <= dctr_q;
			if (state_q == S_LOUT) begin
				res.kind <= gitm_pkg::KIND_LIST;
				res.ctr <= crd;
				res.last <= (({1'b0, idx_q} + 1'b1) == tcnt_q);
			end else if (!(state_q == S_TEST && is_match)) begin
				if (table_full) begin
					res.dropped <= 1'b1;
					res.id <= '0;
					res.box <= '0;
					res.ctr <= '0;
				end else begin
					res.is_new <= 1'b1;
					res.id <= tcnt_q[gitm_pkg::IdBits-1:0];
					res.box <= det_q;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/greedy_iou_track_matcher_top.sv @@
// Top level of the greedy IoU track matcher.
// Detection: strobe once the scanner has taken it and found no committed track, else after
// the committed tracks tested, each through read, overlap, products, threshold, compare.
// End of frame: track records follow in order, each through a read and an output state.
// A two-beat queue lets start be taken while the scanner works; busy is high when full.
// Reset clears track counts, sets threshold to 128; RAMs not cleared; receiver cannot stall.
`default_nettype none
module greedy_iou_track_matcher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [11:0] det_x,
	input  wire logic [11:0] det_y,
	input  wire logic [11:0] det_w,
	input  wire logic [11:0] det_h,
	input  wire logic        cfg_we,
	input  wire logic [8:0]  cfg_wdata,
	output logic             strobe,
	output logic             kind,
	output logic [5:0]       track_id,
	output logic             is_new,
	output logic             dropped,
	output logic [11:0]      box_x,
	output logic [11:0]      box_y,
	output logic [11:0]      box_w,
	output logic [11:0]      box_h,
	output logic [12:0]      center_x,
	output logic [12:0]      center_y,
	output logic             last
);
	logic [gitm_pkg::ThrBits-1:0] thr_q;
	gitm_pkg::item_t item, q_item;
	gitm_pkg::res_t res;
	logic q_valid, pop, full, idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= gitm_pkg::ThrReset;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	assign item = '{cmd: cmd, box: '{x: det_x, y: det_y, w: det_w, h: det_h}};
	assign busy = full;

	gitm_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy_in(busy), .item_in(item),
		.pop(pop), .q_valid(q_valid), .q_item(q_item), .full(full));
	gitm_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .thr(thr_q),
		.pop(pop), .idle(idle), .res_valid(strobe), .res(res));

	assign kind = res.kind;
	assign track_id = res.id;
	assign is_new = res.is_new;
	assign dropped = res.dropped;
	assign box_x = res.box.x;
	assign box_y = res.box.y;
	assign box_w = res.box.w;
	assign box_h = res.box.h;
	assign center_x = res.ctr.cx;
	assign center_y = res.ctr.cy;
	assign last = res.last;

	a_new_not_drop: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(is_new && dropped)) else $error("new and dropped together");
	a_list_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind) |-> (!is_new && !dropped)) else $error("listing flags set");
	a_det_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !kind) |-> last) else $error("detection result without last");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && !q_valid && $past(idle)) |=> !strobe) else $error("result while idle");
endmodule
`default_nettype wire

@@ tb/tb_greedy_iou_track_matcher_top.sv @@
// Self-checking testbench for the greedy IoU track matcher top level.
`default_nettype none
module tb_greedy_iou_track_matcher_top;
	logic clk, arst_n, start, busy, cmd, cfg_we, strobe;
	logic [11:0] det_x, det_y, det_w, det_h;
	logic [8:0] cfg_wdata;
	logic kind, is_new, dropped, last;
	logic [5:0] track_id;
	logic [11:0] box_x, box_y, box_w, box_h;
	logic [12:0] center_x, center_y;

	greedy_iou_track_matcher_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.det_x(det_x), .det_y(det_y), .det_w(det_w), .det_h(det_h),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .strobe(strobe), .kind(kind),
		.track_id(track_id), .is_new(is_new), .dropped(dropped),
		.box_x(box_x), .box_y(box_y), .box_w(box_w), .box_h(box_h),
		.center_x(center_x), .center_y(center_y), .last(last)
	);

	// predictor state
	gitm_pkg::box_t trk_box [gitm_pkg::MaxTracks];
	gitm_pkg::ctr_t trk_ctr [gitm_pkg::MaxTracks];
	int unsigned n_tracks, n_committed;
	logic [gitm_pkg::ThrBits-1:0] thr;

	gitm_pkg::res_t pending_results [$];
	int unsigned errors, n_items, n_results, n_matched, n_new, n_dropped, n_frames;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#80000000;
		$display("timeout");
		$display("** greedy_iou_track_matcher_top: FAILED **");
		$finish;
	end

	function automatic bit overlaps_enough(gitm_pkg::box_t a, gitm_pkg::box_t b,
		logic [gitm_pkg::ThrBits-1:0] t);
		longint unsigned x1, y1, x2, y2, iw, ih, inter, uni;
		x1 = (a.x > b.x) ? a.x : b.x;
		y1 = (a.y > b.y) ? a.y : b.y;
		x2 = ((a.x + 64'(a.w)) < (b.x + 64'(b.w))) ? a.x + 64'(a.w) : b.x + 64'(b.w);
		y2 = ((a.y + 64'(a.h)) < (b.y + 64'(b.h))) ? a.y + 64'(a.h) : b.y + 64'(b.h);
		iw = (x2 > x1) ? x2 - x1 : 0;
		ih = (y2 > y1) ? y2 - y1 : 0;
		inter = iw * ih;
		uni = 64'(a.w) * a.h + 64'(b.w) * b.h - inter;
		if (uni == 0) return 1'b0;
		return inter * 256 > 64'(t) * uni;
	endfunction

	task automatic predict_tracks(logic c, gitm_pkg::box_t d);
		gitm_pkg::res_t r;
		gitm_pkg::ctr_t cc;
		bit hit;
		hit = 1'b0;
		if (c == gitm_pkg::CMD_EOF) begin
			n_committed = n_tracks;
			n_frames++;
			for (int i = 0; i < n_tracks; i++) begin
				r = '0;
				r.kind = gitm_pkg::KIND_LIST;
				r.id = i[gitm_pkg::IdBits-1:0];
				r.box = trk_box[i];
				r.ctr = trk_ctr[i];
				r.last = (i + 1 == n_tracks);
				pending_results.insert(pending_results.size(), r);
			end
			return;
		end
		cc.cx = d.x + (d.w >> 1);
		cc.cy = d.y + (d.h >> 1);
		r = '0;
		r.kind = gitm_pkg::KIND_DET;
		r.last = 1'b1;
		for (int i = 0; i < n_committed && !hit; i++)
			if (overlaps_enough(d, trk_box[i], thr)) begin
				hit = 1'b1;
				trk_ctr[i] = cc;
				r.id = i[gitm_pkg::IdBits-1:0];
				r.box = trk_box[i];
				r.ctr = cc;
				n_matched++;
			end
		if (!hit) begin
			if (n_tracks < gitm_pkg::MaxTracks) begin
				trk_box[n_tracks] = d;
				trk_ctr[n_tracks] = cc;
				r.id = n_tracks[gitm_pkg::IdBits-1:0];
				r.is_new = 1'b1;
				r.box = d;
				r.ctr = cc;
				n_tracks++;
				n_new++;
			end else begin
				r.dropped = 1'b1;
				n_dropped++;
			end
		end
		pending_results.insert(pending_results.size(), r);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		gitm_pkg::res_t e;
		if (arst_n && strobe) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch("result beats beyond expected", n_results, n_results - 1);
			end else begin
				e = pending_results.pop_front();
				if (kind !== e.kind) report_mismatch("kind", kind, e.kind);
				if (track_id !== e.id) report_mismatch("track_id", track_id, e.id);
				if (is_new !== e.is_new) report_mismatch("is_new", is_new, e.is_new);
				if (dropped !== e.dropped) report_mismatch("dropped", dropped, e.dropped);
				if (box_x !== e.box.x) report_mismatch("box_x", box_x, e.box.x);
				if (box_y !== e.box.y) report_mismatch("box_y", box_y, e.box.y);
				if (box_w !== e.box.w) report_mismatch("box_w", box_w, e.box.w);
				if (box_h !== e.box.h) report_mismatch("box_h", box_h, e.box.h);
				if (center_x !== e.ctr.cx) report_mismatch("center_x", center_x, e.ctr.cx);
				if (center_y !== e.ctr.cy) report_mismatch("center_y", center_y, e.ctr.cy);
				if (last !== e.last) report_mismatch("last", last, e.last);
			end
		end
	end

	bit quiet_stretch;

	// start stays high after the accepting edge until the next beat or a drain drops it
	task automatic send_beat(logic c, gitm_pkg::box_t d);
		if (!quiet_stretch)
			while ($urandom_range(99) < 12) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start <= 1'b1;
		cmd <= c;
		det_x <= d.x;
		det_y <= d.y;
		det_w <= d.w;
		det_h <= d.h;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_tracks(c, d);
		n_items++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_threshold(logic [gitm_pkg::ThrBits-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr = v;
		@(posedge clk);
	endtask

	function automatic gitm_pkg::box_t rand_box();
		gitm_pkg::box_t b;
		if ($urandom_range(3) == 0) begin
			b.x = 12'($urandom); b.y = 12'($urandom);
			b.w = 12'($urandom); b.h = 12'($urandom);
		end else begin
			b.x = 12'($urandom_range(600)); b.y = 12'($urandom_range(600));
			b.w = 12'($urandom_range(300)); b.h = 12'($urandom_range(300));
		end
		return b;
	endfunction

	// near copy of a box so that matches are frequent
	function automatic gitm_pkg::box_t jitter(gitm_pkg::box_t b);
		gitm_pkg::box_t j;
		j.x = 12'(b.x + $urandom_range(6) - 3);
		j.y = 12'(b.y + $urandom_range(6) - 3);
		j.w = 12'(b.w + $urandom_range(4) - 2);
		j.h = 12'(b.h + $urandom_range(4) - 2);
		return j;
	endfunction

	typedef struct {
		logic c;
		gitm_pkg::box_t d;
		bit typed;
		gitm_pkg::res_t want;
	} row_t;

	row_t rows [$];
	row_t rw;
	gitm_pkg::box_t bx;

	initial begin
		arst_n = 1'b0;
		start = 1'b0; cmd = gitm_pkg::CMD_DET;
		det_x = '0; det_y = '0; det_w = '0; det_h = '0;
		cfg_we = 1'b0; cfg_wdata = '0;
		thr = gitm_pkg::ThrReset;
		n_tracks = 0; n_committed = 0; errors = 0; quiet_stretch = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: empty listing, extremes, zero union, match, listing
		rw = '{gitm_pkg::CMD_EOF, '0, 1'b0, '0}; rows.insert(rows.size(), rw);
		rw = '{gitm_pkg::CMD_DET, '{12'd0, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{gitm_pkg::KIND_DET, 6'd0, 1'b1, 1'b0, '0, '0, 1'b1}};
		rows.insert(rows.size(), rw);
		rw = '{gitm_pkg::CMD_DET, '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b1,
			'{gitm_pkg::KIND_DET, 6'd1, 1'b1, 1'b0, '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF},
			'{13'd6142, 13'd6142}, 1'b1}};
		rows.insert(rows.size(), rw);
		rw = '{gitm_pkg::CMD_DET, '{12'd100, 12'd100, 12'd50, 12'd40}, 1'b0, '0};
		rows.insert(rows.size(), rw);
		rw = '{gitm_pkg::CMD_EOF, '0, 1'b0, '0}; rows.insert(rows.size(), rw);
		rw = '{gitm_pkg::CMD_DET, '{12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, '0};
		rows.insert(rows.size(), rw);
		rw = '{gitm_pkg::CMD_DET, '{12'd102, 12'd101, 12'd50, 12'd40}, 1'b0, '0};
		rows.insert(rows.size(), rw);
		rw = '{gitm_pkg::CMD_DET, '{12'hFFE, 12'hFFE, 12'd1, 12'd1}, 1'b0, '0};
		rows.insert(rows.size(), rw);
		rw = '{gitm_pkg::CMD_DET, '{12'hAAA, 12'h555, 12'h555, 12'hAAA}, 1'b0, '0};
		rows.insert(rows.size(), rw);
		rw = '{gitm_pkg::CMD_EOF, '0, 1'b0, '0}; rows.insert(rows.size(), rw);
		foreach (rows[k]) begin
			send_beat(rows[k].c, rows[k].d);
			if (rows[k].typed && pending_results[$] != rows[k].want)
				report_mismatch("typed result of directed row", k, -1);
		end

		// threshold extremes: 0, 256, and above 256 where nothing matches
		set_threshold(9'd0);
		send_beat(gitm_pkg::CMD_DET, '{12'd101, 12'd100, 12'd50, 12'd40});
		set_threshold(9'd256);
		send_beat(gitm_pkg::CMD_DET, '{12'd100, 12'd100, 12'd50, 12'd40});
		set_threshold(9'h1FF);
		send_beat(gitm_pkg::CMD_DET, '{12'd100, 12'd100, 12'd50, 12'd40});
		send_beat(gitm_pkg::CMD_EOF, '0);
		set_threshold(9'd100);

		// random frames of boxes near known tracks, some noise
		for (int f = 0; f < 40; f++) begin
			quiet_stretch = (f >= 10 && f < 16);
			if (f == 20) set_threshold(9'($urandom_range(256)));
			if (f == 30) set_threshold(9'($urandom_range(511)));
			for (int k = $urandom_range(15, 4); k > 0; k--) begin
				if (n_committed != 0 && $urandom_range(99) < 65)
					bx = jitter(trk_box[$urandom_range(n_committed - 1)]);
				else
					bx = rand_box();
				send_beat(gitm_pkg::CMD_DET, bx);
			end
			if (f == 25) drain_results();
			send_beat(gitm_pkg::CMD_EOF, '0);
		end
		// full table: push unmatched boxes with no match possible
		set_threshold(9'h1FF);
		for (int k = 0; k < 20; k++) send_beat(gitm_pkg::CMD_DET, rand_box());
		send_beat(gitm_pkg::CMD_EOF, '0);

		drain_results();
		$display("covered %0d items, %0d results in %0d frames", n_items, n_results, n_frames);
		$display("matched %0d, opened %0d, dropped %0d, mismatches %0d",
			n_matched, n_new, n_dropped, errors);
		if (errors == 0)
			$display("** greedy_iou_track_matcher_top: PASSED **");
		else
			$display("** greedy_iou_track_matcher_top: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
